// ===== design/cfp_pkg.sv =====
`default_nettype none

package cfp_pkg;

  // Packet framing constants.
  localparam logic [7:0]  PKT_MARKER  = 8'hCF;
  localparam logic [3:0]  PKT_HDR_LEN = 4'd6;
  localparam logic [3:0]  MAX_PAYLOAD = 4'd8;

  // CRC-16/DNP in reflected form, with the final inversion.
  localparam logic [15:0] CRC_POLY_REFL = 16'hA6BC;
  localparam logic [15:0] CRC_INIT      = 16'h0000;
  localparam logic [15:0] CRC_XOROUT    = 16'hFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } cfp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_ok;
    logic at_end;
    logic out_full;
  } cfp_status_t;

endpackage

`default_nettype wire

// ===== design/cfp_ctrl.sv =====
`default_nettype none

module cfp_ctrl
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        out_ready,
  input  wire cfp_status_t status,
  output cfp_cmd_t         cmd,
  output logic             in_ready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic state;
  logic state_next;

  // Commands: capture a frame when idle, emit a byte when the output slot frees up.
  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.load = (state == ST_IDLE) && in_valid && status.frame_ok;
    cmd.step = (state == ST_SEND) && (!status.out_full || out_ready);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (cmd.step && status.at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/cfp_datapath.sv =====
`default_nettype none

module cfp_datapath
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfp_cmd_t    cmd,
  output cfp_status_t      status,
  input  wire logic [10:0] can_id,
  input  wire logic [3:0]  data_len,
  input  wire logic [7:0]  byte0,
  input  wire logic [7:0]  byte1,
  input  wire logic [7:0]  byte2,
  input  wire logic [7:0]  byte3,
  input  wire logic [7:0]  byte4,
  input  wire logic [7:0]  byte5,
  input  wire logic [7:0]  byte6,
  input  wire logic [7:0]  byte7,
  input  wire logic [15:0] queue_fill,
  input  wire logic        link_idle,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             last
);

  // One byte through the reflected CRC, one shift per bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  logic [10:0] id_q;
  logic [3:0]  len_q;
  logic [15:0] fill_q;
  logic [7:0]  pay [8];
  logic [3:0]  idx;
  logic [15:0] crc;
  logic [15:0] crc_out;
  logic [3:0]  body_len;
  logic [3:0]  pay_idx;
  logic [7:0]  sel_byte;

  assign body_len = len_q + PKT_HDR_LEN;
  assign pay_idx  = idx - PKT_HDR_LEN;
  assign crc_out  = crc ^ CRC_XOROUT;

  // Status toward the controller.
  always_comb begin
    status.frame_ok = link_idle && (data_len <= MAX_PAYLOAD);
    status.at_end   = (idx == body_len + 4'd1);
    status.out_full = out_valid;
  end

  // Byte selection by position in the packet.
  always_comb begin
    priority if (idx == 4'd0) begin
      sel_byte = PKT_MARKER;
    end else if (idx == 4'd1) begin
      sel_byte = {4'h0, body_len};
    end else if (idx == 4'd2) begin
      sel_byte = fill_q[7:0];
    end else if (idx == 4'd3) begin
      sel_byte = fill_q[15:8];
    end else if (idx == 4'd4) begin
      sel_byte = id_q[7:0];
    end else if (idx == 4'd5) begin
      sel_byte = {5'b00000, id_q[10:8]};
    end else if (idx < body_len) begin
      sel_byte = pay[pay_idx[2:0]];
    end else if (idx == body_len) begin
      sel_byte = crc_out[7:0];
    end else begin
      sel_byte = crc_out[15:8];
    end
  end

  // Frame capture, byte counter and running CRC.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_q   <= can_id;
      len_q  <= data_len;
      fill_q <= queue_fill;
      pay[0] <= byte0;
      pay[1] <= byte1;
      pay[2] <= byte2;
      pay[3] <= byte3;
      pay[4] <= byte4;
      pay[5] <= byte5;
      pay[6] <= byte6;
      pay[7] <= byte7;
      idx    <= 4'd0;
      crc    <= CRC_INIT;
    end else if (cmd.step) begin
      idx <= idx + 4'd1;
      if (idx < body_len) begin
        crc <= crc_byte(crc, sel_byte);
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_byte <= sel_byte;
      last     <= status.at_end;
    end
  end

  // Output valid flag: set on a new byte, cleared when the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/can_frame_packetizer_crc16.sv =====
// CAN frame packetizer with a CRC-16/DNP trailer.
//
// Input channel (in_valid/in_ready) moves one CAN frame per transfer. A frame
// whose data_len exceeds 8, or that arrives while link_idle is low, is taken
// and produces nothing.
// Output channel (out_valid/out_ready) moves one packet byte per transfer:
// marker 0xCF, length, queue fill (low, high), identifier (low, high), the
// payload, then the CRC low and high bytes; last marks the CRC high byte.
// The frame is first captured, and its first byte then enters the output
// register once that register is free. Bytes then follow one per cycle
// while the receiver does not stall; a frame with N payload bytes gives
// N + 8 packet bytes. The byte loop through the CRC unit sets that rate.
// in_ready is high only between packets; the next frame is taken as soon as
// the final byte sits in the output register, even before it is taken.
// A receiver stall holds the output register and pauses the byte counter.
// Reset empties the output register and returns the controller to idle.
`default_nettype none

module can_frame_packetizer_crc16
  import cfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [10:0] can_id,
  input  wire logic [3:0]  data_len,
  input  wire logic [7:0]  byte0,
  input  wire logic [7:0]  byte1,
  input  wire logic [7:0]  byte2,
  input  wire logic [7:0]  byte3,
  input  wire logic [7:0]  byte4,
  input  wire logic [7:0]  byte5,
  input  wire logic [7:0]  byte6,
  input  wire logic [7:0]  byte7,
  input  wire logic [15:0] queue_fill,
  input  wire logic        link_idle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last
);

  cfp_cmd_t    cmd;
  cfp_status_t status;

  // Sequencer.
  cfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  // Frame storage, byte selection, CRC and output register.
  cfp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .can_id     (can_id),
    .data_len   (data_len),
    .byte0      (byte0),
    .byte1      (byte1),
    .byte2      (byte2),
    .byte3      (byte3),
    .byte4      (byte4),
    .byte5      (byte5),
    .byte6      (byte6),
    .byte7      (byte7),
    .queue_fill (queue_fill),
    .link_idle  (link_idle),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .last       (last)
  );

`ifndef SYNTH
  // A dropped frame leaves the block ready for the next one.
  a_drop_stays_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !link_idle) |=> in_ready)
    else $error("dropped frame left the input blocked");

  // A frame that is kept blocks the input while its packet goes out.
  a_keep_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && link_idle && (data_len <= MAX_PAYLOAD)) |=> !in_ready)
    else $error("accepted frame did not start a packet");

  // After the final byte, the next byte shown can only open a new packet.
  a_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (!out_valid || (out_byte == PKT_MARKER)))
    else $error("packet did not restart with the marker byte");
`endif

endmodule

`default_nettype wire

// ===== test/can_frame_packetizer_crc16_tb.sv =====
`timescale 1ns / 1ps

module can_frame_packetizer_crc16_tb;
  import cfp_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned DRAIN_CYCLES  = 24;
  localparam int unsigned RANDOM_FRAMES = 390;
  localparam int unsigned CALM_FROM     = 330;

  // One CAN frame as offered on the input channel.
  typedef struct packed {
    logic [10:0]     can_id;
    logic [3:0]      len;
    logic [7:0][7:0] payload;
    logic [15:0]     fill;
    logic            idle;
  } frame_t;

  // One packet byte as seen on the output channel.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } pkt_byte_t;

  // Builds the expected packet bytes for each accepted frame and checks
  // every output transfer against the oldest one still waiting.
  class packet_scoreboard;
    pkt_byte_t   expected_bytes[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [15:0] crc_dnp_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
    endfunction

    function void note_frame(frame_t f);
      logic [7:0]  pkt [16];
      logic [15:0] crc;
      int          n;
      pkt_byte_t   e;
      // Oversized frames and frames seen on a busy link leave no trace.
      if (f.len > MAX_PAYLOAD || !f.idle) return;
      pkt[0] = PKT_MARKER;
      pkt[1] = {4'd0, f.len} + {4'd0, PKT_HDR_LEN};
      pkt[2] = f.fill[7:0];
      pkt[3] = f.fill[15:8];
      pkt[4] = f.can_id[7:0];
      pkt[5] = {5'd0, f.can_id[10:8]};
      n = 6 + int'(f.len);
      for (int i = 0; i < int'(f.len); i++) pkt[6 + i] = f.payload[i];
      crc = CRC_INIT;
      for (int i = 0; i < n; i++) crc = crc_dnp_byte(crc, pkt[i]);
      crc = crc ^ CRC_XOROUT;
      pkt[n]     = crc[7:0];
      pkt[n + 1] = crc[15:8];
      n = n + 2;
      for (int i = 0; i < n; i++) begin
        e.value = pkt[i];
        e.last  = (i == n - 1);
        expected_bytes.push_back(e);
      end
    endfunction

    function void check_byte(logic [7:0] value, logic last_flag);
      pkt_byte_t e;
      if (expected_bytes.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected output byte %02h (last %0b) at %0t", value, last_flag, $realtime);
        end
        mismatches++;
        return;
      end
      e = expected_bytes.pop_front();
      if (e.value !== value) begin
        if (mismatches < 10) begin
          $display("out_byte mismatch at %0t: expected %02h, got %02h",
                   $realtime, e.value, value);
        end
        mismatches++;
      end
      if (e.last !== last_flag) begin
        if (mismatches < 10) begin
          $display("last mismatch at %0t: expected %0b, got %0b (byte %02h)",
                   $realtime, e.last, last_flag, value);
        end
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [10:0] can_id;
  logic [3:0]  data_len;
  logic [7:0]  byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7;
  logic [15:0] queue_fill;
  logic        link_idle;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        last;

  packet_scoreboard sb;
  logic             calm_tail;
  int unsigned      quiet_cycles;

  can_frame_packetizer_crc16 i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .can_id    (can_id),
    .data_len  (data_len),
    .byte0     (byte0),
    .byte1     (byte1),
    .byte2     (byte2),
    .byte3     (byte3),
    .byte4     (byte4),
    .byte5     (byte5),
    .byte6     (byte6),
    .byte7     (byte7),
    .queue_fill(queue_fill),
    .link_idle (link_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one frame, at times with a short random gap ahead of it, and
  // returns at the falling edge after its transfer.
  task automatic send_frame(input frame_t f);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    can_id     <= f.can_id;
    data_len   <= f.len;
    byte0      <= f.payload[0];
    byte1      <= f.payload[1];
    byte2      <= f.payload[2];
    byte3      <= f.payload[3];
    byte4      <= f.payload[4];
    byte5      <= f.payload[5];
    byte6      <= f.payload[6];
    byte7      <= f.payload[7];
    queue_fill <= f.fill;
    link_idle  <= f.idle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [10:0] id, input logic [3:0] len,
                             input logic [63:0] bytes, input logic [15:0] fill,
                             input logic idle);
    frame_t f;
    f.can_id  = id;
    f.len     = len;
    f.payload = bytes;
    f.fill    = fill;
    f.idle    = idle;
    send_frame(f);
  endtask

  // Receiver: random stall bursts, one long hold-off that backs the block up,
  // and an always-ready tail.
  initial begin : receiver
    int unsigned beat;
    int unsigned span;
    beat      = 0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (beat == 200) begin
        out_ready <= 1'b0;
        span = LONG_HOLD;
      end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        span = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b1;
        span = calm_tail ? 1 : $urandom_range(1, 8);
      end
      repeat (span) @(negedge clk);
      beat++;
    end
  end

  // Transfer monitor and watchdog on cycles with no transfer at all.
  always @(posedge clk) begin : transfer_monitor
    frame_t seen;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        seen.can_id  = can_id;
        seen.len     = data_len;
        seen.payload = {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
        seen.fill    = queue_fill;
        seen.idle    = link_idle;
        sb.note_frame(seen);
      end
      if (out_valid && out_ready) sb.check_byte(out_byte, last);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [3:0] len;
    logic       idle;
    int unsigned kind;
    sb         = new();
    calm_tail  = 1'b0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    can_id     = '0;
    data_len   = '0;
    byte0      = '0;
    byte1      = '0;
    byte2      = '0;
    byte3      = '0;
    byte4      = '0;
    byte5      = '0;
    byte6      = '0;
    byte7      = '0;
    queue_fill = '0;
    link_idle  = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames: field extremes, every payload length, both drop cases.
    send_fields(11'h000, 4'd0, 64'h0, 16'h0000, 1'b1);
    send_fields(11'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    for (int i = 1; i < 8; i++) begin
      send_fields(11'h155 + 11'(i * 97), 4'(i), 64'h0123_4567_89AB_CDEF,
                  16'(i * 4099), 1'b1);
    end
    send_fields(11'h2AA, 4'd9, 64'h1111_2222_3333_4444, 16'h1234, 1'b1);
    send_fields(11'h0F0, 4'd15, 64'hDEAD_BEEF_CAFE_F00D, 16'hABCD, 1'b1);
    send_fields(11'h123, 4'd4, 64'h5555_AAAA_5555_AAAA, 16'h00FF, 1'b0);
    send_fields(11'h7FF, 4'd0, 64'h0, 16'hFFFF, 1'b0);
    send_fields(11'h400, 4'd8, 64'h8040_2010_0804_0201, 16'h8001, 1'b1);
    send_fields(11'h0FF, 4'd8, 64'h0, 16'h00FF, 1'b1);
    send_fields(11'h700, 4'd1, 64'hFFFF_FFFF_FFFF_FF00, 16'hFF00, 1'b1);
    send_fields(11'h001, 4'd2, 64'h0000_0000_0000_FF00, 16'h0001, 1'b1);

    // Random frames: mostly well formed, some oversized, some on a busy link.
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      if (i == CALM_FROM) calm_tail = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        len  = 4'($urandom_range(9, 15));
        idle = 1'($urandom_range(0, 1));
      end else if (kind == 1) begin
        len  = 4'($urandom_range(0, 8));
        idle = 1'b0;
      end else begin
        len  = ($urandom_range(0, 3) == 0) ? 4'd8 : 4'($urandom_range(0, 8));
        idle = 1'b1;
      end
      send_fields(11'($urandom_range(0, 2047)), len, {$urandom, $urandom},
                  16'($urandom_range(0, 65535)), idle);
    end
    in_valid <= 1'b0;

    // Let the last packet drain, then give the block time to show strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== can_frame_packetizer_crc16.f =====
design/cfp_pkg.sv
design/cfp_ctrl.sv
design/cfp_datapath.sv
design/can_frame_packetizer_crc16.sv
test/can_frame_packetizer_crc16_tb.sv
